### hdl/assert_macros.svh
// Shared assertion macros for the tokenizer checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds while reset is high.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/irc_tok_pkg.sv
package irc_tok_pkg;

   // field kinds
   localparam logic [2:0] KIND_DELIM  = 3'd0;
   localparam logic [2:0] KIND_NICK   = 3'd1;
   localparam logic [2:0] KIND_USER   = 3'd2;
   localparam logic [2:0] KIND_HOST   = 3'd3;
   localparam logic [2:0] KIND_CMD    = 3'd4;
   localparam logic [2:0] KIND_MIDDLE = 3'd5;
   localparam logic [2:0] KIND_TRAIL  = 3'd6;
   localparam logic [2:0] KIND_END    = 3'd7;

   // parser phases
   localparam logic [3:0] PH_START       = 4'd0;
   localparam logic [3:0] PH_NICK_FIRST  = 4'd1;
   localparam logic [3:0] PH_NICK        = 4'd2;
   localparam logic [3:0] PH_USER_FIRST  = 4'd3;
   localparam logic [3:0] PH_USER        = 4'd4;
   localparam logic [3:0] PH_HOST_FIRST  = 4'd5;
   localparam logic [3:0] PH_HOST        = 4'd6;
   localparam logic [3:0] PH_GAP_CMD     = 4'd7;
   localparam logic [3:0] PH_CMD         = 4'd8;
   localparam logic [3:0] PH_GAP_PARAM   = 4'd9;
   localparam logic [3:0] PH_MIDDLE      = 4'd10;
   localparam logic [3:0] PH_TRAIL_FIRST = 4'd11;
   localparam logic [3:0] PH_TRAIL       = 4'd12;

   // characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   // largest index the output field can show
   localparam int IDX_MAX = 15;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] field_kind;
      logic [3:0] param_index;
      logic       token_start;
      logic       message_end;
      logic       too_many_params;
   } result_type;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      to_upper = (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? (b - CASE_DIFF) : b;
   endfunction

endpackage

### hdl/irc_tok_parse.sv
module irc_tok_parse #(
   parameter int PARAM_LIMIT = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              in_byte,
   output irc_tok_pkg::result_type result
);

   localparam int CW = $clog2(PARAM_LIMIT + 2);

   logic [3:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic          content_ff, content_in;
   logic          eol, ws, use_idx;
   logic [CW-1:0] idx_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= irc_tok_pkg::PH_START;
         count_ff   <= '0;
         content_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         content_ff <= content_in;
      end
   end

   always_comb begin
      eol        = (in_byte == irc_tok_pkg::CHAR_CR) || (in_byte == irc_tok_pkg::CHAR_LF);
      ws         = irc_tok_pkg::is_ws(in_byte);
      phase_in   = phase_ff;
      count_in   = count_ff;
      content_in = 1'b1;
      use_idx    = 1'b0;
      result                 = '0;
      result.out_byte        = in_byte;
      result.field_kind      = irc_tok_pkg::KIND_DELIM;

      if (eol) begin
         result.field_kind = irc_tok_pkg::KIND_END;
         result.message_end = content_ff;
         phase_in   = irc_tok_pkg::PH_START;
         count_in   = '0;
         content_in = 1'b0;
      end else begin
         unique case (phase_ff) inside
            irc_tok_pkg::PH_GAP_CMD: begin
               if (!ws) begin
                  result.field_kind  = irc_tok_pkg::KIND_CMD;
                  result.token_start = 1'b1;
                  result.out_byte    = irc_tok_pkg::to_upper(in_byte);
                  phase_in           = irc_tok_pkg::PH_CMD;
               end
            end
            irc_tok_pkg::PH_NICK_FIRST, irc_tok_pkg::PH_NICK: begin
               if (in_byte == irc_tok_pkg::CHAR_SPACE) begin
                  phase_in = irc_tok_pkg::PH_GAP_CMD;
               end else if (in_byte == irc_tok_pkg::CHAR_BANG) begin
                  phase_in = irc_tok_pkg::PH_USER_FIRST;
               end else begin
                  result.field_kind  = irc_tok_pkg::KIND_NICK;
                  result.token_start = (phase_ff == irc_tok_pkg::PH_NICK_FIRST);
                  phase_in           = irc_tok_pkg::PH_NICK;
               end
            end
            irc_tok_pkg::PH_USER_FIRST, irc_tok_pkg::PH_USER: begin
               if (in_byte == irc_tok_pkg::CHAR_SPACE) begin
                  phase_in = irc_tok_pkg::PH_GAP_CMD;
               end else if (in_byte == irc_tok_pkg::CHAR_AT) begin
                  phase_in = irc_tok_pkg::PH_HOST_FIRST;
               end else begin
                  result.field_kind  = irc_tok_pkg::KIND_USER;
                  result.token_start = (phase_ff == irc_tok_pkg::PH_USER_FIRST);
                  phase_in           = irc_tok_pkg::PH_USER;
               end
            end
            irc_tok_pkg::PH_HOST_FIRST, irc_tok_pkg::PH_HOST: begin
               if (ws) begin
                  phase_in = irc_tok_pkg::PH_GAP_CMD;
               end else begin
                  result.field_kind  = irc_tok_pkg::KIND_HOST;
                  result.token_start = (phase_ff == irc_tok_pkg::PH_HOST_FIRST);
                  phase_in           = irc_tok_pkg::PH_HOST;
               end
            end
            irc_tok_pkg::PH_CMD: begin
               if (ws) begin
                  phase_in = irc_tok_pkg::PH_GAP_PARAM;
               end else begin
                  result.field_kind = irc_tok_pkg::KIND_CMD;
                  result.out_byte   = irc_tok_pkg::to_upper(in_byte);
               end
            end
            irc_tok_pkg::PH_GAP_PARAM: begin
               if (!ws) begin
                  if (count_ff <= CW'(PARAM_LIMIT)) begin
                     count_in = count_ff + 1'b1;
                  end
                  if (in_byte == irc_tok_pkg::CHAR_COLON) begin
                     phase_in = irc_tok_pkg::PH_TRAIL_FIRST;
                  end else begin
                     result.field_kind  = irc_tok_pkg::KIND_MIDDLE;
                     result.token_start = 1'b1;
                     use_idx            = 1'b1;
                     phase_in           = irc_tok_pkg::PH_MIDDLE;
                  end
               end
            end
            irc_tok_pkg::PH_MIDDLE: begin
               if (ws) begin
                  phase_in = irc_tok_pkg::PH_GAP_PARAM;
               end else begin
                  result.field_kind = irc_tok_pkg::KIND_MIDDLE;
                  use_idx           = 1'b1;
               end
            end
            irc_tok_pkg::PH_TRAIL_FIRST, irc_tok_pkg::PH_TRAIL: begin
               result.field_kind  = irc_tok_pkg::KIND_TRAIL;
               result.token_start = (phase_ff == irc_tok_pkg::PH_TRAIL_FIRST);
               use_idx            = 1'b1;
               phase_in           = irc_tok_pkg::PH_TRAIL;
            end
            default: begin
               // line start, and unused codes behave the same
               if (in_byte == irc_tok_pkg::CHAR_COLON) begin
                  phase_in = irc_tok_pkg::PH_NICK_FIRST;
               end else if (ws) begin
                  phase_in = irc_tok_pkg::PH_GAP_PARAM;
               end else begin
                  result.field_kind  = irc_tok_pkg::KIND_CMD;
                  result.token_start = 1'b1;
                  result.out_byte    = irc_tok_pkg::to_upper(in_byte);
                  phase_in           = irc_tok_pkg::PH_CMD;
               end
            end
         endcase
      end

      idx_wide = (count_in == '0) ? '0 : (count_in - 1'b1);
      if (use_idx) begin
         result.param_index = (idx_wide > CW'(irc_tok_pkg::IDX_MAX)) ?
                              4'(irc_tok_pkg::IDX_MAX) : 4'(idx_wide);
      end
      // the flag looks at the count before a line end clears it
      result.too_many_params = eol ? (count_ff > CW'(PARAM_LIMIT))
                                   : (count_in > CW'(PARAM_LIMIT));
   end

endmodule

### hdl/irc_line_tokenizer.sv
// IRC line tokenizer: tags each received byte with the message part it belongs to.
// Each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result side is not stalled; the parse state updates once per byte.
// Input register and result register decouple both sides, so a byte is taken
// while a finished result still waits. Reset is synchronous, active high, and
// clears the pipeline valids and the parse state to line start.
module irc_line_tokenizer #(
   parameter int PARAM_LIMIT = 15
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // tagged byte stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [11:8] param_index, [15:12] zero
   output logic [4:0]  rsp_tuser,   // [2:0] field_kind, [3] token_start, [4] too_many_params
   output logic        rsp_tlast    // message_end
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result stage
   logic                   out_valid_ff, out_valid_in;
   irc_tok_pkg::result_type out_result_ff;
   irc_tok_pkg::result_type parse_result;

   logic req_accept;
   logic advance;   // item moves from input register to result register

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_result_ff <= parse_result;
      end
   end

   // parse state steps exactly once per byte handed to the result stage
   irc_tok_parse #(
      .PARAM_LIMIT (PARAM_LIMIT)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .result  (parse_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_result_ff.param_index, out_result_ff.out_byte};
   assign rsp_tuser  = {out_result_ff.too_many_params, out_result_ff.token_start,
                        out_result_ff.field_kind};
   assign rsp_tlast  = out_result_ff.message_end;

endmodule

### hdl/irc_tok_checker.sv
`include "assert_macros.svh"

module irc_tok_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [4:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata == req_tdata);

   // a stalled result holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // nothing comes out right after reset
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "result valid after reset")

   // message end only on a line end item
   `CHK_ASSERT(a_end_kind, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tuser[2:0] == irc_tok_pkg::KIND_END, "message end on non line end")

   // index only on parameter bytes
   `CHK_ASSERT(a_idx_zero, clock, reset, rsp_tvalid && rsp_tuser[2:0] != irc_tok_pkg::KIND_MIDDLE && rsp_tuser[2:0] != irc_tok_pkg::KIND_TRAIL |-> rsp_tdata[11:8] == 4'd0, "index on non parameter byte")

   // a rising result needs an earlier accepted item, or earlier request or result activity
   `CHK_ASSERT(a_no_early, clock, reset, $rose(rsp_tvalid) |-> $past(req_seen, 2) || $past(req_seen, 3) || $past(rsp_tvalid, 2) || $past(req_tvalid, 2), "result without accepted item")

endmodule

bind irc_line_tokenizer irc_tok_checker u_irc_tok_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
